FILE: rtl/core/assert_macros.svh
// assertion macros for the rtl files, included by osb_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, prop, msg)
`endif
`endif

FILE: rtl/core/osb_pkg.sv
// types and constants of the square oscillator bank
`timescale 1ns / 1ps
package osb_pkg;

	localparam int OP_W       = 2;
	localparam int NOTE_W     = 7;
	localparam int VEL_W      = 7;
	localparam int PHASE_W    = 32;
	localparam int LEVEL_W    = 8;
	localparam int FULL_SCALE = 127;

	typedef enum logic [OP_W-1:0] {
		OP_NOTE_ON  = 2'd0,
		OP_NOTE_OFF = 2'd1,
		OP_TICK     = 2'd2,
		OP_LOAD     = 2'd3
	} op_t;

	localparam logic CFG_ENABLED = 1'b0;
	localparam logic CFG_BYPASS  = 1'b1;

	typedef struct packed {
		logic               voice_we;
		logic               inc_we;
		logic               act_set;
		logic               act_clr;
		logic [NOTE_W-1:0]  wr_addr;
		logic [PHASE_W-1:0] wr_phase;
		logic [VEL_W-1:0]   wr_level;
		logic [PHASE_W-1:0] wr_inc;
		logic [NOTE_W-1:0]  rd_addr;
	} store_req_t;

	typedef struct packed {
		logic               active;
		logic [PHASE_W-1:0] phase;
		logic [VEL_W-1:0]   level;
		logic [PHASE_W-1:0] inc;
	} store_rsp_t;

endpackage

FILE: rtl/core/osb_in_if.sv
// input item channel: note, tick and load items
`timescale 1ns / 1ps
interface osb_in_if import osb_pkg::*;;
	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    operation;
	logic [NOTE_W-1:0]  note_number;
	logic [VEL_W-1:0]   velocity;
	logic [PHASE_W-1:0] increment_value;

	modport source (output valid, operation, note_number, velocity, increment_value,
		input ready);
	modport sink (input valid, operation, note_number, velocity, increment_value,
		output ready);
endinterface

FILE: rtl/core/osb_out_if.sv
// result item channel: mixed sample level
`timescale 1ns / 1ps
interface osb_out_if import osb_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic signed [LEVEL_W-1:0] sample_level;

	modport source (output valid, sample_level, input ready);
	modport sink (input valid, sample_level, output ready);
endinterface

FILE: rtl/core/poly_square_oscillator_bank.sv
// top level of the polyphonic square oscillator bank
//
// channel  dir  contents
// in_ch    in   operation, note_number, velocity, increment_value
// out_ch   out  sample_level, one per tick item
// cfg      in   cfg_we, cfg_index, cfg_data (enabled, bypass)
//
// note and load items are taken in idle and keep it idle; a tick walks the voice
// memory one voice a cycle, then drains and waits in finish for the output register
// a tick while not running goes straight to finish and gives 0
// reset clears the active flags; voice memory needs no clearing pass
// a stalled result holds in the output register and stalls the next tick in finish
`timescale 1ns / 1ps
module poly_square_oscillator_bank import osb_pkg::*; #(
	parameter int NUM_VOICES = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic      cfg_data,
	osb_in_if.sink    in_ch,
	osb_out_if.source out_ch
);
	store_req_t store_req;
	store_rsp_t store_rsp;

	osb_ctrl #(
		.NUM_VOICES(NUM_VOICES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.store_req (store_req),
		.store_rsp (store_rsp)
	);

	osb_store #(
		.NUM_VOICES(NUM_VOICES)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (store_req),
		.rsp    (store_rsp)
	);

endmodule

FILE: rtl/core/osb_store.sv
// voice and increment memories with active flags
`timescale 1ns / 1ps
module osb_store import osb_pkg::*; #(
	parameter int NUM_VOICES = 128
) (
	input  logic       clk,
	input  logic       arst_n,
	input  store_req_t req,
	output store_rsp_t rsp
);
	localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

	logic [PHASE_W+VEL_W-1:0] voice_mem [NUM_VOICES];
	logic [PHASE_W-1:0]       inc_mem [NUM_VOICES];
	logic [NUM_VOICES-1:0]    active_q;
	logic                     rd_active_q;
	logic [PHASE_W-1:0]       rd_phase_q;
	logic [VEL_W-1:0]         rd_level_q;
	logic [PHASE_W-1:0]       rd_inc_q;
	logic [VW-1:0]            wa;
	logic [VW-1:0]            ra;

	assign wa = req.wr_addr[VW-1:0];
	assign ra = req.rd_addr[VW-1:0];

	always_ff @(posedge clk) begin
		if (req.voice_we) begin
			voice_mem[wa] <= {req.wr_phase, req.wr_level};
		end
		if (req.inc_we) begin
			inc_mem[wa] <= req.wr_inc;
		end
		{rd_phase_q, rd_level_q} <= voice_mem[ra];
		rd_inc_q <= inc_mem[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= '0;
			rd_active_q <= 1'b0;
		end else begin
			if (req.act_set) begin
				active_q[wa] <= 1'b1;
			end else if (req.act_clr) begin
				active_q[wa] <= 1'b0;
			end
			rd_active_q <= active_q[ra];
		end
	end

	assign rsp.active = rd_active_q;
	assign rsp.phase  = rd_phase_q;
	assign rsp.level  = rd_level_q;
	assign rsp.inc    = rd_inc_q;

endmodule

FILE: rtl/core/osb_ctrl.sv
// item decode, voice walk sequencer, mix accumulator and output register
`timescale 1ns / 1ps
`include "assert_macros.svh"
module osb_ctrl import osb_pkg::*; #(
	parameter int NUM_VOICES = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic      cfg_data,
	osb_in_if.sink    in_ch,
	osb_out_if.source out_ch,
	output store_req_t store_req,
	input  store_rsp_t store_rsp
);
	localparam int VW      = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int MAX_SUM = NUM_VOICES * FULL_SCALE;
	localparam int SW      = $clog2(MAX_SUM + 1) + 1;
	localparam logic signed [SW-1:0] POS_FS  = SW'(FULL_SCALE);
	localparam logic signed [SW-1:0] NEG_FS  = SW'(-FULL_SCALE);
	localparam logic signed [SW-1:0] POS_MAX = SW'(MAX_SUM);
	localparam logic signed [SW-1:0] NEG_MAX = SW'(-MAX_SUM);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_FINISH} state_t;

	state_t                    state_q;
	logic [VW-1:0]             rd_idx_q;
	logic                      vld_s1;
	logic [VW-1:0]             idx_s1;
	logic signed [SW-1:0]      sum_q;
	logic                      out_valid_q;
	logic signed [LEVEL_W-1:0] out_level_q;
	logic                      enabled_q;
	logic                      bypass_q;

	logic                      running;
	logic                      in_acc;
	op_t                       op;
	logic                      note_ok;
	logic                      last_idx;
	logic                      out_free;
	logic signed [SW-1:0]      lvl_ext;
	logic signed [LEVEL_W-1:0] level_clamped;

	assign running  = enabled_q & ~bypass_q;
	assign in_acc   = in_ch.valid & in_ch.ready;
	assign op       = op_t'(in_ch.operation);
	assign note_ok  = 32'(in_ch.note_number) < NUM_VOICES;
	assign last_idx = (rd_idx_q == VW'(NUM_VOICES - 1));
	assign out_free = !out_valid_q || out_ch.ready;
	assign lvl_ext  = $signed({{(SW-VEL_W){1'b0}}, store_rsp.level});

	assign in_ch.ready         = (state_q == ST_IDLE);
	assign out_ch.valid        = out_valid_q;
	assign out_ch.sample_level = out_level_q;

	always_comb begin
		priority if (sum_q > POS_FS) begin
			level_clamped = LEVEL_W'(FULL_SCALE);
		end else if (sum_q < NEG_FS) begin
			level_clamped = LEVEL_W'(-FULL_SCALE);
		end else begin
			level_clamped = sum_q[LEVEL_W-1:0];
		end
	end

	always_comb begin
		store_req          = '0;
		store_req.wr_addr  = in_ch.note_number;
		store_req.wr_phase = '0;
		store_req.wr_level = in_ch.velocity;
		store_req.wr_inc   = in_ch.increment_value;
		store_req.rd_addr  = NOTE_W'(rd_idx_q);
		if (in_acc) begin
			unique case (op)
				OP_LOAD: begin
					store_req.inc_we = note_ok;
				end
				OP_NOTE_ON: begin
					if (running && note_ok) begin
						if (in_ch.velocity != '0) begin
							store_req.voice_we = 1'b1;
							store_req.act_set  = 1'b1;
						end else begin
							store_req.act_clr = 1'b1;
						end
					end
				end
				OP_NOTE_OFF: begin
					store_req.act_clr = running && note_ok;
				end
				OP_TICK: begin
				end
			endcase
		end
		// phase write-back of the voice read last cycle
		if (vld_s1 && store_rsp.active) begin
			store_req.voice_we = 1'b1;
			store_req.wr_addr  = NOTE_W'(idx_s1);
			store_req.wr_phase = store_rsp.phase + store_rsp.inc;
			store_req.wr_level = store_rsp.level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
			bypass_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLED: enabled_q <= cfg_data;
				CFG_BYPASS:  bypass_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			idx_s1      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
			out_level_q <= '0;
		end else begin
			vld_s1 <= (state_q == ST_WALK);
			idx_s1 <= rd_idx_q;
			if (vld_s1 && store_rsp.active) begin
				sum_q <= store_rsp.phase[PHASE_W-1] ? sum_q - lvl_ext : sum_q + lvl_ext;
			end
			if (out_ch.ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc && op == OP_TICK) begin
						sum_q    <= '0;
						rd_idx_q <= '0;
						state_q  <= running ? ST_WALK : ST_FINISH;
					end
				end
				ST_WALK: begin
					rd_idx_q <= rd_idx_q + VW'(1);
					if (last_idx) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_level_q <= level_clamped;
						state_q     <= ST_IDLE;
					end
				end
			endcase
		end
	end

	`ASSERT_PROP(a_sum_bound, clk, arst_n, (sum_q <= POS_MAX) && (sum_q >= NEG_MAX), "mix sum out of range")
	`ASSERT_PROP(a_out_from_finish, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_FINISH), "result without finished tick")
	`ASSERT_PROP(a_event_no_walk, clk, arst_n, (in_acc && op != OP_TICK) |=> (state_q == ST_IDLE), "event item left idle")
	`ASSERT_PROP(a_walk_end, clk, arst_n, (state_q == ST_WALK && last_idx) |=> (state_q == ST_DRAIN && vld_s1), "walk did not drain")
	`ASSERT_NEVER(a_wb_outside_walk, clk, arst_n, vld_s1 && in_acc, "write-back overlaps an item")

endmodule
